### hw/rtl/pidsc_pkg.sv
package pidsc_pkg;

  // Field and register widths.
  localparam int SPEED_W    = 32;
  localparam int DRIVE_W    = 19;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int GAIN_W     = 24;
  localparam int TIME_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int ERR_W      = 33;
  localparam int INTEG_W    = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH    = 3'd6;

  // Register reset values.
  localparam logic [SPEED_W-1:0] SETPOINT_RST      = 32'd0;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 24'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST        = 24'd58982;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 24'd393;
  localparam logic [TIME_W-1:0]  SAMPLE_PERIOD_RST = 16'd655;
  localparam logic [TIME_W-1:0]  SAMPLE_RATE_RST   = 16'd100;
  localparam logic [COUNT_W-1:0] RUN_LENGTH_RST    = 16'd10;

  // Output scaling: 12.0 V in Q.16 is the clamp, and 1023/3072 equals 341/1024.
  localparam int VOLT_LIMIT  = 786432;
  localparam int DRIVE_SCALE = 341;
  localparam int ROUND_HALF  = 512;

  // Products formed by the shared serial multiplier, in the order they run.
  localparam logic [2:0] OP_INTEG = 3'd0;
  localparam logic [2:0] OP_DERIV = 3'd1;
  localparam logic [2:0] OP_KD    = 3'd2;
  localparam logic [2:0] OP_KP    = 3'd3;
  localparam logic [2:0] OP_KI    = 3'd4;

endpackage

### hw/rtl/pid_speed_controller.sv
// Discrete PID speed controller. Each transfer on the input channel carries one measured
// speed sample in signed Q15.16; the block answers with exactly one result transfer that
// carries the drive value in signed Q10.8, clamped to +-1023.0, and a run_finished flag
// that is set when this sample ended the run and cleared the integral, the last error and
// the sample counter. A new sample is accepted only while the block is idle. All
// arithmetic goes through one serial-parallel multiplier that consumes one multiplier
// bit per cycle. Each sample passes through the accepting step, five products that run
// one after another (integral step, derivative, and the three gain terms), each followed
// by a step that consumes it, a clamping step, and a step that rounds and loads the
// output register. That last step stalls while the output register still holds an
// earlier result that has not been taken. The finished result sits in the output
// register, so the next sample is taken while the previous result still waits.
// Configuration registers are written through the plain write port; the user must write
// them only while the block is idle, which the block itself does not enforce. Writes
// to an index beyond the register list are ignored.
module pid_speed_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pidsc_pkg::SPEED_W-1:0] measured_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidsc_pkg::DRIVE_W-1:0] drive,
  output logic                                run_finished,
  input  logic                                cfg_write,
  input  logic [pidsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import pidsc_pkg::*;

  // Datapath widths of the serial multiplier. The multiplicand is the widest operand
  // (the derivative), the high half carries one extra bit for the running sum, and the
  // multiplier register also collects the low product bits as they shift out.
  localparam int MCAND_W = 50;
  localparam int HI_W    = MCAND_W + 1;
  localparam int MPL_W   = GAIN_W;
  localparam int PF_W    = HI_W + MPL_W - 16;
  localparam int VOLT_W  = PF_W + 2;
  localparam int MAG_W   = 20;
  localparam int SCL_W   = 29;
  localparam int CNT_W   = $clog2(MPL_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_POST  = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic signed [VOLT_W-1:0] VLIM_POS = VOLT_W'(VOLT_LIMIT);
  localparam logic signed [VOLT_W-1:0] VLIM_NEG = -VLIM_POS;

  // Configuration registers.
  logic [SPEED_W-1:0] setpoint;
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [TIME_W-1:0]  sample_period;
  logic [TIME_W-1:0]  sample_rate;
  logic [COUNT_W-1:0] run_length;

  // Controller state carried from sample to sample.
  logic [INTEG_W-1:0] integral_sum;
  logic [ERR_W-1:0]   previous_error;
  logic [COUNT_W-1:0] sample_count;

  // Sequencer.
  logic [2:0]       state;
  logic [2:0]       op;
  logic [CNT_W-1:0] bit_cnt;

  // Datapath registers.
  logic [ERR_W-1:0]          err_q;
  logic [MCAND_W-1:0]        mcand;
  logic [HI_W-1:0]           hi;
  logic [MPL_W-1:0]          ml;
  logic signed [VOLT_W-1:0]  volt;
  logic [MAG_W-1:0]          mag;
  logic                      neg;

  // Combinational signals.
  logic                 in_xfer;
  logic                 slot_free;
  logic [ERR_W-1:0]     err_in;
  logic [HI_W-1:0]      addend;
  logic [HI_W-1:0]      step_sum;
  logic [PF_W-1:0]      prod_floor;
  logic [MCAND_W-1:0]   prod_low;
  logic [ERR_W:0]       err_diff;
  logic [INTEG_W:0]     integ_wide;
  logic [INTEG_W-1:0]   integ_sat;
  logic [VOLT_W-1:0]    pf_ext;
  logic [MAG_W:0]       volt_low;
  logic [MAG_W:0]       volt_abs;
  logic [SCL_W-1:0]     scaled;
  logic [DRIVE_W-1:0]   q_mag;
  logic [DRIVE_W-1:0]   drive_next;
  logic [COUNT_W-1:0]   count_inc;
  logic                 run_end;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Error of the incoming sample, exact in Q16.16.
  assign err_in = {setpoint[SPEED_W-1], setpoint} - {measured_speed[SPEED_W-1], measured_speed};

  // One shift-add step: add the multiplicand when the current multiplier bit is set, then
  // shift the whole product register right by one with the sign kept.
  assign addend   = ml[0] ? {mcand[MCAND_W-1], mcand} : '0;
  assign step_sum = hi + addend;

  // After all steps {hi, ml} holds the exact product. The low bits give the derivative,
  // and dropping the lowest 16 bits gives the product floored to Q.16.
  assign prod_floor = {hi, ml[MPL_W-1:16]};
  assign prod_low   = {hi[MCAND_W-MPL_W-1:0], ml};
  assign pf_ext     = {{2{prod_floor[PF_W-1]}}, prod_floor};

  assign err_diff = {err_q[ERR_W-1], err_q} - {previous_error[ERR_W-1], previous_error};

  // Integral step is at most 34 bits wide; the sum saturates at 48 bits.
  assign integ_wide = {integral_sum[INTEG_W-1], integral_sum}
                    + {{(INTEG_W - ERR_W){prod_floor[ERR_W]}}, prod_floor[ERR_W:0]};
  always_comb begin
    case (integ_wide[INTEG_W:INTEG_W-1])
      2'b01:   integ_sat = {1'b0, {(INTEG_W - 1){1'b1}}};
      2'b10:   integ_sat = {1'b1, {(INTEG_W - 1){1'b0}}};
      default: integ_sat = integ_wide[INTEG_W-1:0];
    endcase
  end

  // Magnitude of an in-range drive voltage (only used when |volt| <= 12.0).
  assign volt_low = volt[MAG_W:0];
  assign volt_abs = volt[VOLT_W-1] ? (~volt_low + 1'b1) : volt_low;

  // Drive = round(mag * 341 / 1024) with halves away from zero, sign applied afterward.
  assign scaled     = SCL_W'(mag) * SCL_W'(DRIVE_SCALE) + SCL_W'(ROUND_HALF);
  assign q_mag      = scaled[SCL_W-1:10];
  assign drive_next = neg ? (~q_mag + 1'b1) : q_mag;

  assign count_inc = sample_count + 1'b1;
  assign run_end   = (run_length != '0) && (count_inc == run_length);

  // Control state, configuration and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_INTEG;
      bit_cnt        <= '0;
      out_valid      <= 1'b0;
      setpoint       <= SETPOINT_RST;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      sample_period  <= SAMPLE_PERIOD_RST;
      sample_rate    <= SAMPLE_RATE_RST;
      run_length     <= RUN_LENGTH_RST;
      integral_sum   <= '0;
      previous_error <= '0;
      sample_count   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SETPOINT:      setpoint      <= cfg_data;
          REG_GAIN_P:        gain_p        <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:        gain_i        <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:        gain_d        <= cfg_data[GAIN_W-1:0];
          REG_SAMPLE_PERIOD: sample_period <= cfg_data[TIME_W-1:0];
          REG_SAMPLE_RATE:   sample_rate   <= cfg_data[TIME_W-1:0];
          REG_RUN_LENGTH:    run_length    <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      // In the final step a taken result is replaced by the new one below.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state   <= S_MUL;
            op      <= OP_INTEG;
            bit_cnt <= '0;
          end
        end
        S_MUL: begin
          if (bit_cnt == CNT_W'(MPL_W - 1)) begin
            bit_cnt <= '0;
            state   <= S_POST;
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
          end
        end
        S_POST: begin
          // Each product is consumed here and the next one is set up.
          case (op)
            OP_INTEG: begin
              integral_sum <= integ_sat;
              op           <= OP_DERIV;
              state        <= S_MUL;
            end
            OP_DERIV: begin
              previous_error <= err_q;
              op             <= OP_KD;
              state          <= S_MUL;
            end
            OP_KD: begin
              op    <= OP_KP;
              state <= S_MUL;
            end
            OP_KP: begin
              op    <= OP_KI;
              state <= S_MUL;
            end
            default: begin
              state <= S_CLAMP;
            end
          endcase
        end
        S_CLAMP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // The result waits here until the output register is free.
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (run_end) begin
              integral_sum   <= '0;
              previous_error <= '0;
              sample_count   <= '0;
            end else begin
              sample_count <= count_inc;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; their contents only matter once the sequencer has loaded them.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          err_q <= err_in;
          mcand <= {{(MCAND_W - ERR_W){err_in[ERR_W-1]}}, err_in};
          hi    <= '0;
          ml    <= {{(MPL_W - TIME_W){1'b0}}, sample_period};
        end
      end
      S_MUL: begin
        hi <= {step_sum[HI_W-1], step_sum[HI_W-1:1]};
        ml <= {step_sum[0], ml[MPL_W-1:1]};
      end
      S_POST: begin
        hi <= '0;
        case (op)
          OP_INTEG: begin
            mcand <= {{(MCAND_W - ERR_W - 1){err_diff[ERR_W]}}, err_diff};
            ml    <= {{(MPL_W - TIME_W){1'b0}}, sample_rate};
          end
          OP_DERIV: begin
            // The derivative feeds the next product straight from the product register.
            mcand <= prod_low;
            ml    <= gain_d;
          end
          OP_KD: begin
            volt  <= pf_ext;
            mcand <= {{(MCAND_W - ERR_W){err_q[ERR_W-1]}}, err_q};
            ml    <= gain_p;
          end
          OP_KP: begin
            volt  <= volt + pf_ext;
            mcand <= {{(MCAND_W - INTEG_W){integral_sum[INTEG_W-1]}}, integral_sum};
            ml    <= gain_i;
          end
          default: begin
            volt <= volt + pf_ext;
          end
        endcase
      end
      S_CLAMP: begin
        if (volt > VLIM_POS) begin
          mag <= MAG_W'(VOLT_LIMIT);
          neg <= 1'b0;
        end else if (volt < VLIM_NEG) begin
          mag <= MAG_W'(VOLT_LIMIT);
          neg <= 1'b1;
        end else begin
          mag <= volt_abs[MAG_W-1:0];
          neg <= volt[VOLT_W-1];
        end
      end
      S_DONE: begin
        if (slot_free) begin
          drive        <= drive_next;
          run_finished <= run_end;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is still in progress");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= 19'sd261888) && (drive >= -19'sd261888))
    else $error("drive outside the clamp range");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && slot_free && run_end
    |=> (sample_count == '0) && (integral_sum == '0) && (previous_error == '0)
        && run_finished)
    else $error("run end did not clear the controller state");

  a_mag_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (mag <= MAG_W'(VOLT_LIMIT)))
    else $error("voltage magnitude beyond the clamp");

  a_counter_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_MUL) |-> (bit_cnt == '0))
    else $error("bit counter running outside a multiply");
`endif

endmodule

### tb/pid_drive_check_pkg.sv
package pid_drive_check_pkg;

  import pidsc_pkg::*;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      finished;
  } drive_result_t;

  localparam longint INTEG_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;
  localparam longint VOLT_CLAMP = VOLT_LIMIT;

  class pid_drive_checker;

    // Register copies.
    logic signed [SPEED_W-1:0] setpoint;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [TIME_W-1:0]         period;
    logic [TIME_W-1:0]         rate;
    logic [COUNT_W-1:0]        run_len;

    // Controller state.
    longint                    integ_sum;
    longint                    last_err;
    logic [COUNT_W-1:0]        count;

    drive_result_t             expected_drive[$];
    int                        mismatches;
    int                        samples;
    int                        results;
    int                        run_ends;
    int                        clamped;

    function new();
      setpoint   = SETPOINT_RST;
      gain_p     = GAIN_P_RST;
      gain_i     = GAIN_I_RST;
      gain_d     = GAIN_D_RST;
      period     = SAMPLE_PERIOD_RST;
      rate       = SAMPLE_RATE_RST;
      run_len    = RUN_LENGTH_RST;
      integ_sum  = 0;
      last_err   = 0;
      count      = '0;
      mismatches = 0;
      samples    = 0;
      results    = 0;
      run_ends   = 0;
      clamped    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SETPOINT:      setpoint = data;
        REG_GAIN_P:        gain_p   = data[GAIN_W-1:0];
        REG_GAIN_I:        gain_i   = data[GAIN_W-1:0];
        REG_GAIN_D:        gain_d   = data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: period   = data[TIME_W-1:0];
        REG_SAMPLE_RATE:   rate     = data[TIME_W-1:0];
        REG_RUN_LENGTH:    run_len  = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(gain * x / 2^16), split so that no product leaves 64 bits.
    function longint gain_term(logic [GAIN_W-1:0] gain, longint x);
      longint g;
      longint hi;
      longint lo;
      g  = longint'(gain);
      hi = x >>> 16;
      lo = x - (hi <<< 16);
      return g * hi + ((g * lo) >>> 16);
    endfunction

    function void note_sample(logic signed [SPEED_W-1:0] speed);
      longint        err;
      longint        deriv;
      longint        integ;
      longint        volt;
      longint        mag;
      longint        q;
      drive_result_t r;
      err   = longint'(setpoint) - longint'(speed);
      deriv = (err - last_err) * longint'(rate);
      integ = integ_sum + ((err * longint'(period)) >>> 16);
      if (integ > INTEG_MAX) integ = INTEG_MAX;
      if (integ < INTEG_MIN) integ = INTEG_MIN;
      integ_sum = integ;
      last_err  = err;
      count     = count + 1'b1;

      volt = gain_term(gain_p, err) + gain_term(gain_i, integ) + gain_term(gain_d, deriv);
      if (volt > VOLT_CLAMP) volt = VOLT_CLAMP;
      if (volt < -VOLT_CLAMP) volt = -VOLT_CLAMP;
      mag = (volt < 0) ? -volt : volt;
      if (mag == VOLT_CLAMP) clamped++;
      // Scale by 1023/12 into Q10.8, rounding halves away from zero.
      q = (mag * 1023 + 1536) / 3072;
      r.drive    = DRIVE_W'((volt < 0) ? -q : q);
      r.finished = (run_len != 0) && (count == run_len);
      if (r.finished) begin
        integ_sum = 0;
        last_err  = 0;
        count     = '0;
        run_ends++;
      end
      samples++;
      expected_drive.push_back(r);
    endfunction

    function void check_result(logic signed [DRIVE_W-1:0] drive, logic finished);
      drive_result_t want;
      results++;
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d arrived with nothing expected: drive %0d run_finished %0b",
                   results, drive, finished);
        end
        return;
      end
      want = expected_drive.pop_front();
      if (want.drive !== drive || want.finished !== finished) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d: drive %0d expected %0d, run_finished %0b expected %0b",
                   results, drive, want.drive, finished, want.finished);
        end
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

  endclass

endpackage

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidsc_pkg::*;
  import pid_drive_check_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_SAMPLES = 600;
  localparam int IDLE_PCT       = 34;
  // A quiet stretch far beyond the receiver hold-off plus two samples of work
  // means the block has hung.
  localparam int HOLD_CYCLES    = 1500;
  localparam int QUIET_LIMIT    = 6000;
  localparam int TAIL_CYCLES    = 300;
  // The one index that lies past the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                        clk            = 1'b0;
  logic                        rst            = 1'b1;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic signed [SPEED_W-1:0]   measured_speed = '0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic signed [DRIVE_W-1:0]   drive;
  logic                        run_finished;
  logic                        cfg_write      = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index      = '0;
  logic [CFG_DATA_W-1:0]       cfg_data       = '0;

  pid_drive_checker chk;

  // Shared between the sender and the receiver: calm switches random idling
  // off on both sides, and phase_no tells the receiver when to hold off.
  bit calm     = 1'b0;
  int phase_no = 0;
  int quiet    = 0;
  int reg_writes = 0;

  pid_speed_controller dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_speed (measured_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive          (drive),
    .run_finished   (run_finished),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Both channels are observed at the rising edge. Every sample accepted
  // on the input side runs through the predictor at once, and every result
  // transfer is compared with the oldest prediction still waiting.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) chk.note_sample(measured_speed);
      if (out_valid && out_ready) chk.check_result(drive, run_finished);
    end
  end

  // Watchdog: any transfer or register write counts as progress. A long run of
  // cycles without any of them ends the simulation as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results still expected",
               QUIET_LIMIT, chk.pending());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver. It drops ready about a third of the time, keeps it high while
  // calm is set, and once, when the third random phase starts, holds off for
  // a long stretch so that the result register and then the input back up.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && phase_no == 3) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one sample and returns once its transfer has happened. Valid is
  // left high so that back-to-back samples need not drop it and raise it again.
  task automatic send_sample(logic [SPEED_W-1:0] speed);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    measured_speed = speed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Every sample yields exactly one result, so the block is idle afterwards.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (chk.pending() != 0) @(negedge clk);
  endtask

  // One register write, mirrored into the predictor at the edge that takes it.
  task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    chk.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Gains are mostly modest so that the drive often stays inside the clamp,
  // with zero, full scale and fully random values mixed in.
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom());
      default: return GAIN_W'($urandom_range(32'h0004_0000));
    endcase
  endfunction

  // Period and rate: usually a plausible value, sometimes zero, one, the
  // top value or anything at all.
  function automatic logic [TIME_W-1:0] rand_time(int lo, int hi);
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      3:       return TIME_W'($urandom());
      default: return TIME_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // Most speed samples sit near the setpoint, where the controller does more
  // than saturate; one in five is any 32-bit value at all.
  function automatic logic [SPEED_W-1:0] rand_speed();
    case ($urandom_range(4))
      0:       return $urandom();
      1:       return chk.setpoint - ($urandom_range(32'h0004_0000) - 32'h0002_0000);
      default: return chk.setpoint - ($urandom_range(32'h0040_0000) - 32'h0020_0000);
    endcase
  endfunction

  // New settings for a random phase. Each register is rewritten with a
  // probability of three in four, so some settings carry over between phases.
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] sp;
    logic [COUNT_W-1:0]    len;
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(7))
        0:       sp = 32'h7FFF_FFFF;
        1:       sp = 32'h8000_0000;
        2:       sp = $urandom();
        default: sp = $urandom_range(32'h0200_0000) - 32'h0100_0000;
      endcase
      load_reg(REG_SETPOINT, sp);
    end
    if ($urandom_range(3) != 0) load_reg(REG_GAIN_P, CFG_DATA_W'(rand_gain()));
    if ($urandom_range(3) != 0) load_reg(REG_GAIN_I, CFG_DATA_W'(rand_gain()));
    if ($urandom_range(3) != 0) load_reg(REG_GAIN_D, CFG_DATA_W'(rand_gain()));
    if ($urandom_range(3) != 0) begin
      load_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'(rand_time(100, 2000)));
    end
    if ($urandom_range(3) != 0) begin
      load_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rand_time(10, 1000)));
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(9))
        0, 1:    len = '0;
        2:       len = 16'd1;
        3:       len = '1;
        default: len = COUNT_W'($urandom_range(40, 2));
      endcase
      load_reg(REG_RUN_LENGTH, CFG_DATA_W'(len));
    end
    if ($urandom_range(9) == 0) load_reg(REG_UNUSED, $urandom());
  endtask

  // Directed opening. The comments track the sample counter, since the
  // run-length cases depend on where it stands.
  task automatic directed_part();
    logic [SPEED_W-1:0] basics [11] = '{
      32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'h0010_0000, 32'hFFF0_0000,
      32'h0000_0000
    };
    // Reset settings: the run of ten ends on the tenth sample, which must still
    // carry a drive computed from its own error. The counter ends at one.
    foreach (basics[i]) send_sample(basics[i]);
    drain();

    // Endless run with every gain, the period, the rate and the setpoint at
    // their top values; the speed extremes drive the error to both ends.
    load_reg(REG_RUN_LENGTH, 32'd0);
    load_reg(REG_SETPOINT, 32'h7FFF_FFFF);
    load_reg(REG_GAIN_P, 32'h00FF_FFFF);
    load_reg(REG_GAIN_I, 32'h00FF_FFFF);
    load_reg(REG_GAIN_D, 32'h00FF_FFFF);
    load_reg(REG_SAMPLE_PERIOD, 32'h0000_FFFF);
    load_reg(REG_SAMPLE_RATE, 32'h0000_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    drain();

    // The counter stands at five. A run length of one is below it, so the
    // count keeps going and none of these samples ends a run.
    load_reg(REG_SETPOINT, 32'h8000_0000);
    load_reg(REG_GAIN_P, 32'd0);
    load_reg(REG_GAIN_I, 32'd0);
    load_reg(REG_GAIN_D, 32'd0);
    load_reg(REG_SAMPLE_PERIOD, 32'd1);
    load_reg(REG_SAMPLE_RATE, 32'd1);
    load_reg(REG_RUN_LENGTH, 32'd1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    drain();

    // The counter stands at eight, so a run length of nine ends the run on
    // the next sample. Zero period and rate null the integral step and the derivative
    // term, and a write past the register list must change nothing.
    load_reg(REG_RUN_LENGTH, 32'd9);
    load_reg(REG_SAMPLE_PERIOD, 32'd0);
    load_reg(REG_SAMPLE_RATE, 32'd0);
    load_reg(REG_GAIN_P, 32'h0000_8000);
    load_reg(REG_GAIN_I, 32'h00FF_FFFF);
    load_reg(REG_GAIN_D, 32'h00FF_FFFF);
    load_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(32'h0123_4567);
    drain();

    // Run length one with the counter cleared: every sample ends a run.
    load_reg(REG_RUN_LENGTH, 32'd1);
    send_sample(32'h0000_1000);
    send_sample(32'hFFFF_F000);
  endtask

  initial begin : stimulus
    int phase_len;
    int sent;
    chk  = new();
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_part();

    // Random phases. Settings change only with the block empty. Phase two
    // pauses halfway until every result is back, phase three meets the long
    // receiver hold-off, and phases five and six run with no idling at all.
    while (sent < RANDOM_SAMPLES) begin
      drain();
      random_settings();
      phase_no++;
      calm      = (phase_no == 5 || phase_no == 6);
      phase_len = $urandom_range(70, 20);
      for (int i = 0; i < phase_len; i++) begin
        if (phase_no == 2 && i == phase_len / 2) drain();
        send_sample(rand_speed());
        sent++;
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples over %0d random phases and %0d register writes;",
             chk.samples, phase_no, reg_writes);
    $display("%0d samples ended a run and %0d hit the drive clamp; %0d mismatches.",
             chk.run_ends, chk.clamped, chk.mismatches);
    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
